// File: hw/rtl/modbus_rtu_response_checker_unit_defines.svh
// ----------------------------------------------------------------------------
// Modbus RTU response checker - assertion macros
// Shared property macros for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_RESPONSE_CHECKER_UNIT_DEFINES_SVH
`define MODBUS_RTU_RESPONSE_CHECKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define MRRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define MRRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/mrrc_pkg.sv
// ----------------------------------------------------------------------------
// Modbus RTU response checker - package
// Types, codes and constants shared by the checker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mrrc_pkg;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [7:0]  EXC_MASK      = 8'h80;
    localparam logic [6:0]  MAX_QUANTITY  = 7'd123;
    localparam logic [7:0]  RETRY_RESET   = 8'd3;
    localparam logic [7:0]  FUNC_READ_HLD = 8'd3;
    localparam logic [7:0]  FUNC_READ_INP = 8'd4;
    localparam logic [7:0]  WRITE_LEN     = 8'd8;
    localparam logic [7:0]  EXC_LEN       = 8'd5;
    localparam logic [7:0]  READ_OVERHEAD = 8'd5;
    localparam logic [7:0]  COUNT_MAX     = 8'd255;

    typedef enum logic [1:0] {
        ACT_ARM     = 2'd0,
        ACT_BYTE    = 2'd1,
        ACT_TIMEOUT = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        KIND_WORD    = 2'd0,
        KIND_FRAME   = 2'd1,
        KIND_TIMEOUT = 2'd2,
        KIND_REJECT  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] function_code;
        logic [6:0] quantity;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] reg_word;
        logic        crc_ok;
        logic        exception_flag;
        logic [7:0]  exception_code;
        logic [7:0]  retry_count;
        logic        give_up;
        logic        last;
    } rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/mrrc_crc_byte.sv
// ----------------------------------------------------------------------------
// Modbus RTU response checker - CRC byte update
// One byte through CRC-16/Modbus, reflected, eight shifts unrolled.
// ----------------------------------------------------------------------------
`default_nettype none

module mrrc_crc_byte
    import mrrc_pkg::*;
(
    input  wire logic [15:0] crc_in,
    input  wire logic [7:0]  data_in,
    output logic      [15:0] crc_out
);

    always_comb begin
        logic [15:0] c;
        c = crc_in ^ {8'h00, data_in};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

// File: hw/rtl/mrrc_frame_ctl.sv
// ----------------------------------------------------------------------------
// Modbus RTU response checker - frame control
// Frame state, byte counting, word assembly and status for one transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module mrrc_frame_ctl
    import mrrc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step_en,
    input  wire item_t      item,
    input  wire logic [7:0] retry_limit,
    output logic            rsp_valid,
    output rsp_t            rsp
);

    logic        receiving_reg,    receiving_next;
    logic [7:0]  byte_pos_reg,     byte_pos_next;
    logic [7:0]  exp_len_reg,      exp_len_next;
    logic        read_req_reg,     read_req_next;
    logic [7:0]  high_hold_reg,    high_hold_next;
    logic [15:0] crc_reg,          crc_next;
    logic [7:0]  crc_low_reg,      crc_low_next;
    logic        exc_seen_reg,     exc_seen_next;
    logic [7:0]  exc_code_reg,     exc_code_next;
    logic [7:0]  tmo_count_reg,    tmo_count_next;

    logic [15:0] crc_fed;
    logic        is_read;
    logic        exc_now;
    logic [8:0]  pos_plus2;
    logic [8:0]  frame_len;
    logic [7:0]  tmo_inc;
    action_t     act;

    mrrc_crc_byte u_crc (
        .crc_in  (crc_reg),
        .data_in (item.rx_byte),
        .crc_out (crc_fed)
    );

    assign act       = action_t'(item.action);
    assign is_read   = (item.function_code == FUNC_READ_HLD) ||
                       (item.function_code == FUNC_READ_INP);
    assign exc_now   = exc_seen_reg ||
                       ((byte_pos_reg == 8'd1) && ((item.rx_byte & EXC_MASK) != 8'h00));
    assign pos_plus2 = {1'b0, byte_pos_reg} + 9'd2;
    assign frame_len = {1'b0, (exc_now ? EXC_LEN : exp_len_reg)};
    assign tmo_inc   = (tmo_count_reg < COUNT_MAX) ? tmo_count_reg + 8'd1 : tmo_count_reg;

    always_comb begin
        receiving_next = receiving_reg;
        byte_pos_next  = byte_pos_reg;
        exp_len_next   = exp_len_reg;
        read_req_next  = read_req_reg;
        high_hold_next = high_hold_reg;
        crc_next       = crc_reg;
        crc_low_next   = crc_low_reg;
        exc_seen_next  = exc_seen_reg;
        exc_code_next  = exc_code_reg;
        tmo_count_next = tmo_count_reg;
        rsp_valid      = 1'b0;
        rsp            = '0;

        unique case (act)
            ACT_ARM: begin
                if (is_read && (item.quantity > MAX_QUANTITY)) begin
                    receiving_next = 1'b0;
                    rsp_valid      = 1'b1;
                    rsp.kind       = KIND_REJECT;
                end else begin
                    read_req_next  = is_read;
                    exp_len_next   = is_read ? ({item.quantity, 1'b0} + READ_OVERHEAD)
                                             : WRITE_LEN;
                    receiving_next = 1'b1;
                    tmo_count_next = '0;
                    byte_pos_next  = '0;
                    high_hold_next = '0;
                    crc_next       = CRC_INIT;
                    crc_low_next   = '0;
                    exc_seen_next  = 1'b0;
                    exc_code_next  = '0;
                end
            end
            ACT_BYTE: begin
                if (receiving_reg) begin
                    exc_seen_next = exc_now;
                    byte_pos_next = byte_pos_reg + 8'd1;
                    if (pos_plus2 < frame_len) begin
                        crc_next = crc_fed;
                        if (exc_now && (byte_pos_reg == 8'd2)) begin
                            exc_code_next = item.rx_byte;
                        end
                        if (read_req_reg && !exc_now && (byte_pos_reg >= 8'd3)) begin
                            if (byte_pos_reg[0]) begin
                                high_hold_next = item.rx_byte;
                            end else begin
                                rsp_valid    = 1'b1;
                                rsp.kind     = KIND_WORD;
                                rsp.reg_word = {high_hold_reg, item.rx_byte};
                            end
                        end
                    end else if (pos_plus2 == frame_len) begin
                        crc_low_next = item.rx_byte;
                    end else begin
                        rsp_valid          = 1'b1;
                        rsp.kind           = KIND_FRAME;
                        rsp.crc_ok         = (crc_reg == {item.rx_byte, crc_low_reg});
                        rsp.exception_flag = exc_now;
                        rsp.exception_code = exc_now ? exc_code_reg : 8'h00;
                        rsp.retry_count    = tmo_count_reg;
                        rsp.last           = 1'b1;
                        tmo_count_next     = '0;
                        receiving_next     = 1'b0;
                        byte_pos_next      = '0;
                        high_hold_next     = '0;
                        crc_next           = CRC_INIT;
                        crc_low_next       = '0;
                        exc_seen_next      = 1'b0;
                        exc_code_next      = '0;
                    end
                end
            end
            ACT_TIMEOUT: begin
                if (receiving_reg) begin
                    tmo_count_next  = tmo_inc;
                    byte_pos_next   = '0;
                    high_hold_next  = '0;
                    crc_next        = CRC_INIT;
                    crc_low_next    = '0;
                    exc_seen_next   = 1'b0;
                    exc_code_next   = '0;
                    rsp_valid       = 1'b1;
                    rsp.kind        = KIND_TIMEOUT;
                    rsp.retry_count = tmo_inc;
                    rsp.last        = 1'b1;
                    if (tmo_inc >= retry_limit) begin
                        rsp.give_up    = 1'b1;
                        receiving_next = 1'b0;
                    end
                end
            end
            default: begin
                // unused action code: drop
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            receiving_reg <= 1'b0;
            byte_pos_reg  <= '0;
            exp_len_reg   <= '0;
            read_req_reg  <= 1'b0;
            high_hold_reg <= '0;
            crc_reg       <= CRC_INIT;
            crc_low_reg   <= '0;
            exc_seen_reg  <= 1'b0;
            exc_code_reg  <= '0;
            tmo_count_reg <= '0;
        end else if (step_en) begin
            receiving_reg <= receiving_next;
            byte_pos_reg  <= byte_pos_next;
            exp_len_reg   <= exp_len_next;
            read_req_reg  <= read_req_next;
            high_hold_reg <= high_hold_next;
            crc_reg       <= crc_next;
            crc_low_reg   <= crc_low_next;
            exc_seen_reg  <= exc_seen_next;
            exc_code_reg  <= exc_code_next;
            tmo_count_reg <= tmo_count_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/modbus_rtu_response_checker_unit.sv
// ----------------------------------------------------------------------------
// Modbus RTU response checker - top level
// Input channel carries arm, received-byte and timeout transactions; the
// result channel carries register words, frame status, timeout status and
// arm rejections. retry_limit is written through cfg_we / cfg_wdata.
//
// Usage:
//   - s_tuser selects the action (arm, byte, timeout); s_tdata carries the
//     function code, register quantity and received byte.
//   - m_tuser gives the result kind, m_tlast marks a closing status, m_tdata
//     carries the word and status fields.
//   - Path: an accepted input transaction waits in the input register, then
//     its result is loaded into the result register.
//   - Throughput: one transaction per cycle unless the output stalls; the CRC
//     byte update is unrolled in the single step between the two registers.
//   - Reset (aresetn low, synchronous): both registers empty, block idle,
//     CRC at 0xFFFF, retry_limit back to 3.
//   - Stall: while m_tready is low the result register holds; the input
//     register holds its transaction and s_tready drops once both are full.
//   - Write the configuration only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "modbus_rtu_response_checker_unit_defines.svh"

module modbus_rtu_response_checker_unit
    import mrrc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] function_code, [14:8] quantity, [22:15] rx_byte, [23] zero
    input  wire logic [23:0] s_tdata,
    // [1:0] action
    input  wire logic [1:0]  s_tuser,
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] reg_word, [16] crc_ok, [17] exception_flag,
    // [25:18] exception_code, [33:26] retry_count, [34] give_up, [39:35] zero
    output logic      [39:0] m_tdata,
    // [1:0] kind
    output logic      [1:0]  m_tuser,
    output logic             m_tlast,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata
);

    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       out_valid_reg;
    rsp_t       out_rsp_reg;
    logic [7:0] retry_limit_reg;

    logic       advance;
    logic       step_valid;
    rsp_t       step_rsp;

    // Advance the held transaction when the result slot is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    mrrc_frame_ctl u_frame (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .item        (in_item_reg),
        .retry_limit (retry_limit_reg),
        .rsp_valid   (step_valid),
        .rsp         (step_rsp)
    );

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            retry_limit_reg <= RETRY_RESET;
        end else if (cfg_we) begin
            retry_limit_reg <= cfg_wdata;
        end
    end

    // Input register: capture a transaction, release it when it advances.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.action        <= s_tuser;
            in_item_reg.function_code <= s_tdata[7:0];
            in_item_reg.quantity      <= s_tdata[14:8];
            in_item_reg.rx_byte       <= s_tdata[22:15];
        end
    end

    // Result register: load on advance, empty when taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= step_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && step_valid) begin
            out_rsp_reg <= step_rsp;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_rsp_reg.kind;
    assign m_tlast  = out_rsp_reg.last;
    assign m_tdata  = {5'b00000,
                       out_rsp_reg.give_up,
                       out_rsp_reg.retry_count,
                       out_rsp_reg.exception_code,
                       out_rsp_reg.exception_flag,
                       out_rsp_reg.crc_ok,
                       out_rsp_reg.reg_word};

    // Closing marker goes with frame and timeout status only.
    `MRRC_ASSERT_NOW(a_last_kind, aclk, aresetn, out_valid_reg, (out_rsp_reg.last == ((out_rsp_reg.kind == KIND_FRAME) || (out_rsp_reg.kind == KIND_TIMEOUT))), "tlast does not match result kind")
    // Give-up only accompanies a timeout status.
    `MRRC_ASSERT_NOW(a_give_up_kind, aclk, aresetn, out_valid_reg && out_rsp_reg.give_up, (out_rsp_reg.kind == KIND_TIMEOUT), "give_up on a non-timeout result")
    // A held input transaction that cannot advance stays put.
    `MRRC_ASSERT_NEXT(a_in_hold, aclk, aresetn, in_valid_reg && !advance, in_valid_reg && $stable(in_item_reg), "stalled input transaction lost")

endmodule

`default_nettype wire
